/* hw/rtl/sac_pkg.sv */
// Shared types, constants and register codes for the set-associative LRU cache model.
`default_nettype none
package sac_pkg;

	localparam int SAC_MAX_SET_BITS = 6;
	localparam int SAC_MAX_WAYS     = 8;
	localparam int SAC_STAMP_BITS   = 32;

	localparam int SAC_ADDR_BITS  = 64;
	localparam int SAC_CNT_BITS   = 32;
	localparam int SAC_WAY_IDX_W  = 4;
	localparam int SAC_CFG_IDX_W  = 2;
	localparam int SAC_CFG_DATA_W = 5;

	localparam logic [SAC_CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
	localparam logic [SAC_CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
	localparam logic [SAC_CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

	localparam logic [2:0] RST_SET_INDEX_BITS = 3'd1;
	localparam logic [4:0] RST_OFFSET_BITS    = 5'd4;
	localparam logic [3:0] RST_WAYS_IN_USE    = 4'd1;

	typedef struct packed {
		logic                     op;
		logic [SAC_ADDR_BITS-1:0] address;
		logic [31:0]              access_stamp;
	} sac_in_t;

	typedef struct packed {
		logic                    was_hit;
		logic                    was_evict;
		logic [SAC_CNT_BITS-1:0] hit_total;
		logic [SAC_CNT_BITS-1:0] miss_total;
		logic [SAC_CNT_BITS-1:0] evict_total;
	} sac_out_t;

	typedef struct packed {
		logic                     hit;
		logic                     empty;
		logic [SAC_WAY_IDX_W-1:0] way;
	} sac_scan_res_t;

endpackage
`default_nettype wire

/* hw/rtl/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU cache model: sequencer, line store and totals.
//
//   channel  dir  handshake          beat
//   in       in   in_valid/in_stall  op, address, access_stamp
//   out      out  out_valid/out_stall was_hit, was_evict, hit/miss/evict totals
//   cfg      in   cfg_valid/cfg_ready register index, write data
//
// An access reads nw ways, nw being ways_in_use held to 1..MAX_WAYS: the ways of the
// set are read one per cycle from the single read port of the line store and checked by
// one shared compare unit. After reset a clearing pass writes every line, during which
// in_stall stays high. A waiting result sits in the output register; the next access is
// taken meanwhile and holds in its final step until the output register frees up.
// cfg_ready is always high.
`default_nettype none
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = sac_pkg::SAC_MAX_SET_BITS,
	parameter int MAX_WAYS     = sac_pkg::SAC_MAX_WAYS,
	parameter int STAMP_BITS   = sac_pkg::SAC_STAMP_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  sac_pkg::sac_in_t             in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output sac_pkg::sac_out_t                  out_data,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [sac_pkg::SAC_CFG_IDX_W-1:0]  cfg_index,
	input  wire  [sac_pkg::SAC_CFG_DATA_W-1:0] cfg_data
);
	import sac_pkg::*;

	localparam int DEPTH  = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(MAX_WAYS + 1);
	localparam int ENT_W  = 1 + SAC_ADDR_BITS + STAMP_BITS;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_UPD   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [2:0] set_bits_q;
	logic [4:0] offset_q;
	logic [3:0] ways_q;

	logic                     op_q;
	logic [SAC_ADDR_BITS-1:0] addr_q;
	logic [STAMP_BITS-1:0]    stamp_q;
	logic [SAC_ADDR_BITS-1:0] tag_q;
	logic [ADDR_W-1:0]        base_q;
	logic [CNT_W-1:0]         nw_q;
	logic [CNT_W-1:0]         iss_q;
	logic                     rd_pend_s1;
	logic [CNT_W-1:0]         rd_way_s1;
	logic [ADDR_W-1:0]        clr_q;
	logic                     was_hit_q;
	logic                     was_evict_q;

	logic [SAC_CNT_BITS-1:0] hit_cnt_q;
	logic [SAC_CNT_BITS-1:0] miss_cnt_q;
	logic [SAC_CNT_BITS-1:0] evict_cnt_q;

	logic [2:0]               sb;
	logic [CNT_W-1:0]         nw;
	logic [SAC_ADDR_BITS-1:0] blk;
	logic [MAX_SET_BITS-1:0]  set_idx;
	logic [5:0]               tag_shift;
	logic [SAC_ADDR_BITS-1:0] tag_c;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;

	sac_scan_res_t scan_res;
	logic          scan_start;

	logic [1:0]              hit_inc;
	logic [SAC_CNT_BITS:0]   hit_sum;
	logic                    miss_now;
	logic                    evict_now;
	logic                    out_load;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);

	// Clamp the configuration and split the address.
	always_comb begin
		if (32'(set_bits_q) > MAX_SET_BITS) begin
			sb = 3'(MAX_SET_BITS);
		end else begin
			sb = set_bits_q;
		end
		if (ways_q == 4'd0) begin
			nw = CNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			nw = CNT_W'(MAX_WAYS);
		end else begin
			nw = CNT_W'(ways_q);
		end
		blk       = addr_q >> offset_q;
		set_idx   = MAX_SET_BITS'(blk) & ~({MAX_SET_BITS{1'b1}} << sb);
		tag_shift = {1'b0, offset_q} + {3'b000, sb};
		tag_c     = addr_q >> tag_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= RST_SET_INDEX_BITS;
			offset_q   <= RST_OFFSET_BITS;
			ways_q     <= RST_WAYS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_INDEX_BITS: set_bits_q <= cfg_data[2:0];
				CFG_OFFSET_BITS:    offset_q   <= cfg_data[4:0];
				CFG_WAYS_IN_USE:    ways_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	sac_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign scan_start = (state_q == ST_PREP);

	sac_scan #(
		.STAMP_BITS(STAMP_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.en       (rd_pend_s1),
		.way      (SAC_WAY_IDX_W'(rd_way_s1)),
		.tag      (tag_q),
		.ent_valid(ram_rdata[ENT_W-1]),
		.ent_tag  (ram_rdata[STAMP_BITS +: SAC_ADDR_BITS]),
		.ent_age  (ram_rdata[STAMP_BITS-1:0]),
		.res      (scan_res)
	);

	always_comb begin
		ram_raddr = base_q + ADDR_W'(iss_q);
		ram_we    = 1'b0;
		ram_waddr = base_q + ADDR_W'(scan_res.way);
		ram_wdata = {1'b1, tag_q, stamp_q};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_UPD: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Second lookup of a modify always hits.
	assign hit_inc   = {1'b0, scan_res.hit} + {1'b0, op_q};
	assign hit_sum   = {1'b0, hit_cnt_q} + (SAC_CNT_BITS + 1)'(hit_inc);
	assign miss_now  = !scan_res.hit;
	assign evict_now = !scan_res.hit && !scan_res.empty;
	assign out_load  = (state_q == ST_DONE) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			iss_q       <= '0;
			rd_pend_s1  <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (32'(clr_q) == DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					iss_q      <= '0;
					rd_pend_s1 <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_pend_s1 && (rd_way_s1 == nw_q - CNT_W'(1))) begin
						rd_pend_s1 <= 1'b0;
						state_q    <= ST_UPD;
					end else if (iss_q < nw_q) begin
						iss_q      <= iss_q + CNT_W'(1);
						rd_pend_s1 <= 1'b1;
					end else begin
						rd_pend_s1 <= 1'b0;
					end
				end
				ST_UPD: begin
					if (hit_sum[SAC_CNT_BITS]) begin
						hit_cnt_q <= '1;
					end else begin
						hit_cnt_q <= hit_sum[SAC_CNT_BITS-1:0];
					end
					if (miss_now && (miss_cnt_q != '1)) begin
						miss_cnt_q <= miss_cnt_q + SAC_CNT_BITS'(1);
					end
					if (evict_now && (evict_cnt_q != '1)) begin
						evict_cnt_q <= evict_cnt_q + SAC_CNT_BITS'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_way_s1 <= iss_q;
		case (state_q)
			ST_IDLE: begin
				op_q    <= in_data.op;
				addr_q  <= in_data.address;
				stamp_q <= STAMP_BITS'({{STAMP_BITS{1'b0}}, in_data.access_stamp});
			end
			ST_PREP: begin
				tag_q  <= tag_c;
				base_q <= ADDR_W'(32'(set_idx) * MAX_WAYS);
				nw_q   <= nw;
			end
			ST_UPD: begin
				was_hit_q   <= scan_res.hit;
				was_evict_q <= evict_now;
			end
			default: ;
		endcase
		if (out_load) begin
			out_data.was_hit     <= was_hit_q;
			out_data.was_evict   <= was_evict_q;
			out_data.hit_total   <= hit_cnt_q;
			out_data.miss_total  <= miss_cnt_q;
			out_data.evict_total <= evict_cnt_q;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/sac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/sac_scan.sv */
// Shared tag and age compare unit that walks the ways of one set.
`default_nettype none
module sac_scan #(
	parameter int STAMP_BITS = sac_pkg::SAC_STAMP_BITS
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire                                 en,
	input  wire [sac_pkg::SAC_WAY_IDX_W-1:0]    way,
	input  wire [sac_pkg::SAC_ADDR_BITS-1:0]    tag,
	input  wire                                 ent_valid,
	input  wire [sac_pkg::SAC_ADDR_BITS-1:0]    ent_tag,
	input  wire [STAMP_BITS-1:0]                ent_age,
	output sac_pkg::sac_scan_res_t              res
);
	import sac_pkg::*;

	logic                     hit_q;
	logic                     emp_q;
	logic [SAC_WAY_IDX_W-1:0] hit_way_q;
	logic [SAC_WAY_IDX_W-1:0] emp_way_q;
	logic [SAC_WAY_IDX_W-1:0] vic_way_q;
	logic [STAMP_BITS-1:0]    old_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			emp_q <= 1'b0;
		end else if (start) begin
			hit_q <= 1'b0;
			emp_q <= 1'b0;
		end else if (en) begin
			if (ent_valid && (ent_tag == tag) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!ent_valid) begin
				emp_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ent_valid && (ent_tag == tag) && !hit_q) begin
				hit_way_q <= way;
			end
			if (!ent_valid) begin
				emp_way_q <= way;
			end
			if ((way == '0) || (ent_age < old_q)) begin
				old_q     <= ent_age;
				vic_way_q <= way;
			end
		end
	end

	always_comb begin
		res.hit   = hit_q;
		res.empty = emp_q;
		if (hit_q) begin
			res.way = hit_way_q;
		end else if (emp_q) begin
			res.way = emp_way_q;
		end else begin
			res.way = vic_way_q;
		end
	end
endmodule
`default_nettype wire
